[sv/wavrsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavrsp_pkg
// Shared types and constants for the WAV RIFF stream parser.
// ----------------------------------------------------------------------------
package wavrsp_pkg;

  // Four-character tags as they appear in a little-endian 32-bit word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_TAG  = 16'h0001;
  localparam logic [15:0] PCM_BITS = 16'd16;

  // RIFF header is "RIFF", size, "WAVE".
  localparam logic [31:0] HDR_LEN = 32'd12;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_CHDR,
    PH_FMT,
    PH_DATA,
    PH_SKIP,
    PH_PAD,
    PH_TAIL,
    PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TOO_SHORT   = 4'd1,
    ST_BAD_RIFF    = 4'd2,
    ST_BAD_WAVE    = 4'd3,
    ST_NO_FMT      = 4'd4,
    ST_NO_DATA     = 4'd5,
    ST_UNSUPPORTED = 4'd6,
    ST_DATA_EARLY  = 4'd7,
    ST_BAD_SIZE    = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        chunk_end;
    logic        done_res;
    logic [3:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [31:0] frame_total;
  } out_item_t;

  // Control from the parser into the fmt field capture.
  typedef struct packed {
    logic       clear;
    logic       capture;
    logic [3:0] offset;
    logic [7:0] data;
  } fmt_ctrl_t;

  // Fields of the fmt chunk as they stand after the current byte.
  typedef struct packed {
    logic        ok;
    logic [1:0]  channels;
    logic [31:0] rate;
  } fmt_info_t;

endpackage

[sv/wav_riff_stream_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// Byte-serial RIFF/WAVE PCM header parser with payload pass-through.
// ----------------------------------------------------------------------------
// The block takes one byte of a WAV file per request and returns exactly one
// result per request, in the cycle after the byte is accepted. It takes a new
// byte in every cycle; the only thing that holds it back is the result
// register, which must be empty or being drained in the same cycle. All parse
// state (header, chunk walk, fmt capture, frame total) moves forward once per
// accepted byte, so the sustained rate is one byte per clock. The
// byte marked as end of file carries the final status, and after it the
// parser is back in its reset state, ready for the next file.
module wav_riff_stream_parser import wavrsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_data,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result_data
);

  // Parser state.
  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [32:0] riff_end_offset, riff_end_offset_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_bytes_left, chunk_bytes_left_next;
  logic [4:0]  chunk_offset, chunk_offset_next;
  logic [1:0]  channels_held, channels_held_next;
  logic [31:0] rate_held, rate_held_next;
  logic        format_found, format_found_next;
  logic [31:0] frames_held, frames_held_next;
  status_t     error_held, error_held_next;

  logic        accept;
  out_item_t   result;
  fmt_ctrl_t   fmt_ctrl;
  fmt_info_t   fmt_info;

  // A new request is taken whenever the result register is free or drains.
  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  // The fmt capture is cleared when a fmt chunk header completes and is offered
  // each of the first sixteen body bytes to load its field bytes from.
  always_comb begin
    fmt_ctrl.clear   = accept && (phase == PH_CHDR) && (chunk_offset[2:0] == 3'd7) &&
                       (tag_shift == TAG_FMT);
    fmt_ctrl.capture = accept && (phase == PH_FMT) && !chunk_offset[4];
    fmt_ctrl.offset  = chunk_offset[3:0];
    fmt_ctrl.data    = byte_data.file_byte;
  end

  wavrsp_fmt_capture u_fmt (
    .clk  (clk),
    .ctrl (fmt_ctrl),
    .info (fmt_info)
  );

  always_comb begin
    logic [7:0]  b;
    logic [31:0] pos_next;
    logic [31:0] left_dec;
    logic [2:0]  hdr_off;
    logic [31:0] frames_add;
    logic        frame_rem;
    logic [32:0] frame_sum;
    logic        go_next;
    logic        end_body;
    logic        judge;
    logic [3:0]  st;

    b          = byte_data.file_byte;
    pos_next   = (byte_position == 32'hFFFF_FFFF) ? byte_position : byte_position + 32'd1;
    left_dec   = (chunk_bytes_left != 32'd0) ? chunk_bytes_left - 32'd1 : 32'd0;
    hdr_off    = chunk_offset[2:0];
    frames_add = '0;
    frame_rem  = 1'b0;
    frame_sum  = '0;
    go_next    = 1'b0;
    end_body   = 1'b0;
    judge      = 1'b0;
    st         = ST_OK;

    phase_next            = phase;
    byte_position_next    = pos_next;
    riff_end_offset_next  = riff_end_offset;
    tag_shift_next        = tag_shift;
    chunk_length_next     = chunk_length;
    chunk_bytes_left_next = chunk_bytes_left;
    chunk_offset_next     = chunk_offset;
    channels_held_next    = channels_held;
    rate_held_next        = rate_held;
    format_found_next     = format_found;
    frames_held_next      = frames_held;
    error_held_next       = error_held;

    result = '0;

    case (phase)
      PH_HDR: begin
        tag_shift_next = {b, tag_shift[31:8]};
        if ((byte_position >= 32'd4) && (byte_position <= 32'd7)) begin
          chunk_length_next = {b, chunk_length[31:8]};
        end
        if ((byte_position == 32'd3) && (tag_shift_next != TAG_RIFF)) begin
          error_held_next = ST_BAD_RIFF;
          phase_next      = PH_STOP;
        end else if (byte_position == 32'd7) begin
          riff_end_offset_next = 33'd8 + {1'b0, chunk_length_next};
        end else if (byte_position == 32'd11) begin
          if (tag_shift_next != TAG_WAVE) begin
            error_held_next = ST_BAD_WAVE;
            phase_next      = PH_STOP;
          end else begin
            go_next = 1'b1;
          end
        end
      end
      PH_CHDR: begin
        if (!hdr_off[2]) begin
          tag_shift_next = {b, tag_shift[31:8]};
        end else begin
          chunk_length_next = {b, chunk_length[31:8]};
        end
        chunk_offset_next = {2'b00, hdr_off} + 5'd1;
        if (hdr_off == 3'd7) begin
          // The chunk header is complete: dispatch on its id.
          chunk_bytes_left_next = chunk_length_next;
          chunk_offset_next     = '0;
          if (tag_shift_next == TAG_FMT) begin
            phase_next = PH_FMT;
            if (chunk_length_next == 32'd0) begin
              judge    = 1'b1;
              end_body = 1'b1;
            end
          end else if (tag_shift_next == TAG_DATA) begin
            if (!format_found || (channels_held == 2'd0)) begin
              error_held_next = ST_DATA_EARLY;
              phase_next      = PH_STOP;
            end else begin
              // A frame is two bytes per channel, so mono divides by two and
              // stereo by four.
              if (channels_held == 2'd1) begin
                frame_rem  = chunk_length_next[0];
                frames_add = {1'b0, chunk_length_next[31:1]};
              end else begin
                frame_rem  = |chunk_length_next[1:0];
                frames_add = {2'b00, chunk_length_next[31:2]};
              end
              if (frame_rem) begin
                error_held_next = ST_BAD_SIZE;
                phase_next      = PH_STOP;
              end else begin
                frame_sum        = {1'b0, frames_held} + {1'b0, frames_add};
                frames_held_next = frame_sum[32] ? 32'hFFFF_FFFF : frame_sum[31:0];
                phase_next       = PH_DATA;
                end_body         = (chunk_length_next == 32'd0);
              end
            end
          end else begin
            phase_next = PH_SKIP;
            end_body   = (chunk_length_next == 32'd0);
          end
        end
      end
      PH_FMT: begin
        if (!chunk_offset[4]) begin
          chunk_offset_next = chunk_offset + 5'd1;
        end
        chunk_bytes_left_next = left_dec;
        judge    = !chunk_offset[4] && ((chunk_offset == 5'd15) || (left_dec == 32'd0));
        end_body = (left_dec == 32'd0);
      end
      PH_DATA: begin
        result.sample_valid   = 1'b1;
        result.sample_byte    = b;
        chunk_bytes_left_next = left_dec;
        if (left_dec == 32'd0) begin
          result.chunk_end = 1'b1;
          end_body         = 1'b1;
        end
      end
      PH_SKIP: begin
        chunk_bytes_left_next = left_dec;
        end_body              = (left_dec == 32'd0);
      end
      PH_PAD: begin
        go_next = 1'b1;
      end
      default: ;
    endcase

    // Judge the fmt fields gathered so far; a failure stops the parse.
    if (judge) begin
      if (!fmt_info.ok) begin
        error_held_next = ST_UNSUPPORTED;
        phase_next      = PH_STOP;
        end_body        = 1'b0;
      end else begin
        channels_held_next = fmt_info.channels;
        rate_held_next     = fmt_info.rate;
        format_found_next  = 1'b1;
      end
    end

    // An odd-length body is followed by one pad byte.
    if (end_body) begin
      if (chunk_length_next[0]) begin
        phase_next = PH_PAD;
      end else begin
        go_next = 1'b1;
      end
    end

    // Walk on to the next chunk only while its start lies inside the region.
    if (go_next) begin
      if ({1'b0, pos_next} < riff_end_offset_next) begin
        phase_next        = PH_CHDR;
        chunk_offset_next = '0;
      end else begin
        phase_next = PH_TAIL;
      end
    end

    if (byte_data.end_of_file) begin
      // A fmt chunk cut short by the end of file is judged as it stands.
      if ((phase_next == PH_FMT) && !chunk_offset_next[4]) begin
        if (!fmt_info.ok) begin
          error_held_next = ST_UNSUPPORTED;
        end else begin
          channels_held_next = fmt_info.channels;
          rate_held_next     = fmt_info.rate;
          format_found_next  = 1'b1;
        end
      end
      if (pos_next < HDR_LEN) begin
        st = ST_TOO_SHORT;
      end else if (error_held_next != ST_OK) begin
        st = error_held_next;
      end else if (!format_found_next) begin
        st = ST_NO_FMT;
      end else if (frames_held_next == 32'd0) begin
        st = ST_NO_DATA;
      end else begin
        st = ST_OK;
      end
      result.done_res = 1'b1;
      result.status   = st;
    end

    result.channel_count = format_found_next ? channels_held_next : 2'd0;
    result.sample_rate   = format_found_next ? rate_held_next : 32'd0;
    result.frame_total   = frames_held_next;

    // The last byte of a file returns the parser to its reset state.
    if (byte_data.end_of_file) begin
      phase_next            = PH_HDR;
      byte_position_next    = '0;
      riff_end_offset_next  = '0;
      tag_shift_next        = '0;
      chunk_length_next     = '0;
      chunk_bytes_left_next = '0;
      chunk_offset_next     = '0;
      channels_held_next    = '0;
      rate_held_next        = '0;
      format_found_next     = 1'b0;
      frames_held_next      = '0;
      error_held_next       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR;
      byte_position    <= '0;
      riff_end_offset  <= '0;
      tag_shift        <= '0;
      chunk_length     <= '0;
      chunk_bytes_left <= '0;
      chunk_offset     <= '0;
      channels_held    <= '0;
      rate_held        <= '0;
      format_found     <= 1'b0;
      frames_held      <= '0;
      error_held       <= ST_OK;
    end else if (accept) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      riff_end_offset  <= riff_end_offset_next;
      tag_shift        <= tag_shift_next;
      chunk_length     <= chunk_length_next;
      chunk_bytes_left <= chunk_bytes_left_next;
      chunk_offset     <= chunk_offset_next;
      channels_held    <= channels_held_next;
      rate_held        <= rate_held_next;
      format_found     <= format_found_next;
      frames_held      <= frames_held_next;
      error_held       <= error_held_next;
    end
  end

  // Result register: loaded on every accepted request, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result;
    end
  end

endmodule

[sv/wavrsp_fmt_capture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavrsp_fmt_capture
// Collects the fields of a fmt chunk body and judges them for 16-bit PCM.
// ----------------------------------------------------------------------------
module wavrsp_fmt_capture import wavrsp_pkg::*; (
  input  logic      clk,
  input  fmt_ctrl_t ctrl,
  output fmt_info_t info
);

  logic [15:0] format_tag;
  logic [15:0] bits;
  logic [15:0] channels;
  logic [31:0] rate;
  logic [15:0] format_tag_next;
  logic [15:0] bits_next;
  logic [15:0] channels_next;
  logic [31:0] rate_next;

  always_comb begin
    format_tag_next = format_tag;
    bits_next       = bits;
    channels_next   = channels;
    rate_next       = rate;
    if (ctrl.clear) begin
      format_tag_next = '0;
      bits_next       = '0;
      channels_next   = '0;
      rate_next       = '0;
    end else if (ctrl.capture) begin
      case (ctrl.offset)
        4'd0:    format_tag_next = {8'h00, ctrl.data};
        4'd1:    format_tag_next = format_tag | {ctrl.data, 8'h00};
        4'd2:    channels_next   = {8'h00, ctrl.data};
        4'd3:    channels_next   = channels | {ctrl.data, 8'h00};
        4'd4:    rate_next       = rate | {24'h0, ctrl.data};
        4'd5:    rate_next       = rate | {16'h0, ctrl.data, 8'h00};
        4'd6:    rate_next       = rate | {8'h0, ctrl.data, 16'h0};
        4'd7:    rate_next       = rate | {ctrl.data, 24'h0};
        4'd14:   bits_next       = {8'h00, ctrl.data};
        4'd15:   bits_next       = bits | {ctrl.data, 8'h00};
        default: ;
      endcase
    end
  end

  // Only mono or stereo 16-bit PCM is accepted.
  assign info.ok = (format_tag_next == PCM_TAG) && (bits_next == PCM_BITS) &&
                   ((channels_next == 16'd1) || (channels_next == 16'd2));
  assign info.channels = channels_next[1:0];
  assign info.rate     = rate_next;

  always_ff @(posedge clk) begin
    format_tag <= format_tag_next;
    bits       <= bits_next;
    channels   <= channels_next;
    rate       <= rate_next;
  end

endmodule
